// ===== src/ipv4_lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 longest prefix match package
// Shared sizes, operation and status codes, and the types that travel
// between the trie level cells and the top level.
// ----------------------------------------------------------------------------
package ipv4_lpm_pkg;

    // Trie sizing.
    localparam int NODE_COUNT   = 1024;
    localparam int ADDRESS_BITS = 32;
    localparam int CELLS        = ADDRESS_BITS + 1;
    localparam int IDX_W        = $clog2(NODE_COUNT);
    localparam int USED_W       = $clog2(NODE_COUNT + 1);
    localparam int LEN_W        = $clog2(ADDRESS_BITS + 1);
    localparam int HOP_W        = 32;

    // Operation codes; the fourth code is a no-op.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    // One trie node as stored in a level memory.
    typedef struct packed {
        logic [1:0]       present;
        logic [IDX_W-1:0] zero_child;
        logic [IDX_W-1:0] one_child;
        logic             valid;
        logic [HOP_W-1:0] hop;
    } t_entry;

    // Operation token handed from one level cell to the next.
    typedef struct packed {
        logic              vld;
        logic [1:0]        op;
        logic [ADDRESS_BITS-1:0] addr;
        logic [LEN_W-1:0]  rem;
        logic [HOP_W-1:0]  hop;
        logic [IDX_W-1:0]  node;
        logic              fresh;
        logic              act;
        logic              found;
        logic [HOP_W-1:0]  rhop;
        logic [LEN_W-1:0]  mlen;
        t_status           status;
        logic [USED_W-1:0] used;
        logic [LEN_W-1:0]  depth;
    } t_tok;

    // One result item.
    typedef struct packed {
        logic             found;
        logic [HOP_W-1:0] hop;
        logic [LEN_W-1:0] mlen;
        t_status          status;
    } t_res;

endpackage

// ===== src/ipv4_lpm_cell.sv =====
// ----------------------------------------------------------------------------
// Trie level cell
// Holds the nodes of one trie depth, takes the token from the level above,
// reads the node it points at, updates it and hands the token onward.
// ----------------------------------------------------------------------------
module ipv4_lpm_cell
    import ipv4_lpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    t_entry r_mem [NODE_COUNT];
    t_entry r_ent;
    t_tok   r_tok;
    logic   r_root_ok;

    t_entry w_ent;
    t_entry w_wdata;
    logic   w_we;
    logic   w_bit;
    logic   w_has;
    logic [IDX_W-1:0] w_child;

    // Token register; the node read is issued with the arriving token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= r_mem[i_tok.node];
        if (w_we) begin
            r_mem[r_tok.node] <= w_wdata;
        end
    end

    // The root entry reads as empty until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ok <= 1'b0;
        end else if (w_we && (r_tok.node == '0)) begin
            r_root_ok <= 1'b1;
        end
    end

    // A freshly allocated node has not been written yet and is empty.
    always_comb begin
        if (r_tok.fresh || ((r_tok.node == '0) && !r_root_ok)) begin
            w_ent = '0;
        end else begin
            w_ent = r_ent;
        end
        w_bit   = r_tok.addr[ADDRESS_BITS-1];
        w_has   = w_ent.present[w_bit];
        w_child = w_bit ? w_ent.one_child : w_ent.zero_child;
    end

    // Step of the walk at this depth.
    always_comb begin
        o_tok       = r_tok;
        o_tok.addr  = r_tok.addr << 1;
        o_tok.depth = r_tok.depth + LEN_W'(1);
        o_tok.fresh = 1'b0;
        w_we        = 1'b0;
        w_wdata     = w_ent;
        if (r_tok.vld && r_tok.act) begin
            case (r_tok.op)
                OP_INSERT: begin
                    if (r_tok.rem == '0) begin
                        w_wdata.valid = 1'b1;
                        w_wdata.hop   = r_tok.hop;
                        w_we          = 1'b1;
                        o_tok.act     = 1'b0;
                    end else if (w_has) begin
                        w_we       = r_tok.fresh;
                        o_tok.node = w_child;
                        o_tok.rem  = r_tok.rem - LEN_W'(1);
                    end else if (r_tok.used >= USED_W'(NODE_COUNT)) begin
                        w_we         = r_tok.fresh;
                        o_tok.status = ST_FULL;
                        o_tok.act    = 1'b0;
                    end else begin
                        w_wdata.present[w_bit] = 1'b1;
                        if (w_bit) begin
                            w_wdata.one_child = r_tok.used[IDX_W-1:0];
                        end else begin
                            w_wdata.zero_child = r_tok.used[IDX_W-1:0];
                        end
                        w_we        = 1'b1;
                        o_tok.node  = r_tok.used[IDX_W-1:0];
                        o_tok.fresh = 1'b1;
                        o_tok.used  = r_tok.used + USED_W'(1);
                        o_tok.rem   = r_tok.rem - LEN_W'(1);
                    end
                end
                OP_LOOKUP: begin
                    if (w_ent.valid) begin
                        o_tok.found = 1'b1;
                        o_tok.rhop  = w_ent.hop;
                        o_tok.mlen  = r_tok.depth;
                    end
                    if ((r_tok.depth == LEN_W'(ADDRESS_BITS)) || !w_has) begin
                        o_tok.act = 1'b0;
                    end else begin
                        o_tok.node = w_child;
                    end
                end
                OP_DELETE: begin
                    if (r_tok.rem == '0) begin
                        if (w_ent.valid) begin
                            w_wdata.valid = 1'b0;
                            w_we          = 1'b1;
                        end else begin
                            o_tok.status = ST_ABSENT;
                        end
                        o_tok.act = 1'b0;
                    end else if (w_has) begin
                        o_tok.node = w_child;
                        o_tok.rem  = r_tok.rem - LEN_W'(1);
                    end else begin
                        o_tok.status = ST_ABSENT;
                        o_tok.act    = 1'b0;
                    end
                end
                default: begin
                    o_tok.act = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== src/ipv4_longest_prefix_match_trie.sv =====
// ----------------------------------------------------------------------------
// IPv4 longest prefix match trie
// Binary trie routing table with insert, lookup and delete, built as a
// chain of level cells through which each operation token travels.
// ----------------------------------------------------------------------------
// An operation's token is registered in each of the 33 trie level cells in
// turn, and its result then in the result queue, before it is valid.
// Throughput: one operation at a time; the token must leave the cell chain
// before the next operation enters, and a full result queue also holds input.
// Reset: clears the root-entry flags, the result queue and the busy flag,
// and sets the node count to one; there is no memory clearing pass.
module ipv4_longest_prefix_match_trie
    import ipv4_lpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_operation,
    input  logic [31:0]       i_address,
    input  logic [5:0]        i_prefix_len,
    input  logic [31:0]       i_next_hop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [31:0]       o_result_hop,
    output logic [5:0]        o_matched_len,
    output logic [1:0]        o_status
);

    t_tok w_link [CELLS+1];
    logic w_acc;
    logic w_push;
    logic w_pop;
    t_res w_res;

    logic              r_busy;
    logic [USED_W-1:0] r_used;
    t_res              r_q0;
    t_res              r_q1;
    logic              r_q0_vld;
    logic              r_q1_vld;
    t_res              n_q0;
    t_res              n_q1;
    logic              n_q0_vld;
    logic              n_q1_vld;

    assign o_ready = !r_busy && !r_q1_vld;
    assign w_acc   = i_valid && o_ready;

    // Token that enters the first cell on an input transfer.
    always_comb begin
        w_link[0].vld  = w_acc;
        w_link[0].op   = i_operation;
        w_link[0].addr = i_address[ADDRESS_BITS-1:0];
        if (i_prefix_len > 6'(ADDRESS_BITS)) begin
            w_link[0].rem = LEN_W'(ADDRESS_BITS);
        end else begin
            w_link[0].rem = i_prefix_len[LEN_W-1:0];
        end
        w_link[0].hop    = i_next_hop;
        w_link[0].node   = '0;
        w_link[0].fresh  = 1'b0;
        w_link[0].act    = (i_operation == OP_INSERT) || (i_operation == OP_LOOKUP)
                           || (i_operation == OP_DELETE);
        w_link[0].found  = 1'b0;
        w_link[0].rhop   = '0;
        w_link[0].mlen   = '0;
        w_link[0].status = ST_DONE;
        w_link[0].used   = r_used;
        w_link[0].depth  = '0;
    end

    // One cell per trie depth, root first.
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        ipv4_lpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    assign w_push       = w_link[CELLS].vld;
    assign w_pop        = r_q0_vld && i_ready;
    assign w_res.found  = w_link[CELLS].found;
    assign w_res.hop    = w_link[CELLS].rhop;
    assign w_res.mlen   = w_link[CELLS].mlen;
    assign w_res.status = w_link[CELLS].status;

    // Busy flag and node count carried back from the chain exit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_used <= USED_W'(1);
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_push) begin
                r_busy <= 1'b0;
            end
            if (w_push) begin
                r_used <= w_link[CELLS].used;
            end
        end
    end

    // Two-entry result queue, so the chain never stalls.
    always_comb begin
        n_q0     = r_q0;
        n_q1     = r_q1;
        n_q0_vld = r_q0_vld;
        n_q1_vld = r_q1_vld;
        if (w_pop) begin
            n_q0     = r_q1;
            n_q0_vld = r_q1_vld;
            n_q1_vld = 1'b0;
        end
        if (w_push) begin
            if (!n_q0_vld) begin
                n_q0     = w_res;
                n_q0_vld = 1'b1;
            end else begin
                n_q1     = w_res;
                n_q1_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
        if (!i_rst_n) begin
            r_q0_vld <= 1'b0;
            r_q1_vld <= 1'b0;
        end else begin
            r_q0_vld <= n_q0_vld;
            r_q1_vld <= n_q1_vld;
        end
    end

    assign o_valid       = r_q0_vld;
    assign o_found       = r_q0.found;
    assign o_result_hop  = r_q0.hop;
    assign o_matched_len = 6'(r_q0.mlen);
    assign o_status      = r_q0.status;

`ifndef SYNTHESIS
    // An accepted operation keeps the chain busy until it leaves.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("chain not busy after input transfer");

    // A token only leaves the chain while an operation is in flight.
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> r_busy)
        else $error("token left the chain with no operation in flight");

    // The result queue fills in order.
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q1_vld |-> r_q0_vld)
        else $error("second queue entry valid without first");

    // A finished token never finds the queue full.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !(r_q1_vld && !w_pop))
        else $error("result queue overflow");

    // The node count never runs past the pool.
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used <= USED_W'(NODE_COUNT)) && (r_used != '0))
        else $error("node count out of range");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 longest prefix match trie testbench
// Drives insert, lookup and delete operations into the trie and predicts
// every result with a behavioral copy of the routing table. A directed part
// covers the corner cases. Random traffic built around a few prefixes then
// grows deep paths, and a long output stall fills the block. A final part
// runs the node pool out of space and keeps operating on the full table.
// ----------------------------------------------------------------------------
module testbench
    import ipv4_lpm_pkg::*;
();

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 40;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int IDLE_PERCENT    = 31;
    localparam int BASE_COUNT      = 12;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_operation  = '0;
    logic [31:0] i_address    = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [31:0] i_next_hop   = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_result_hop;
    logic [5:0]  o_matched_len;
    logic [1:0]  o_status;

    // Behavioral copy of the routing table.
    logic [IDX_W-1:0] trie_zero_idx [NODE_COUNT];
    logic [IDX_W-1:0] trie_one_idx  [NODE_COUNT];
    logic [1:0]       trie_kids     [NODE_COUNT];
    logic             trie_routed   [NODE_COUNT];
    logic [HOP_W-1:0] trie_hop      [NODE_COUNT];
    int unsigned      trie_used;

    t_res        expected_answers [$];
    t_res        head_answer;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    logic        idling_on      = 1'b1;
    int unsigned hold_asks      = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    logic [31:0] route_bases [BASE_COUNT];

    ipv4_longest_prefix_match_trie u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_address     (i_address),
        .i_prefix_len  (i_prefix_len),
        .i_next_hop    (i_next_hop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_result_hop  (o_result_hop),
        .o_matched_len (o_matched_len),
        .o_status      (o_status)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Applies one operation to the table copy and returns its answer.
    function automatic t_res trie_apply(input logic [1:0] op, input logic [31:0] addr,
                                        input logic [5:0] len_in, input logic [31:0] hop);
        t_res        ans;
        int unsigned len;
        int unsigned node;
        int unsigned fresh;
        int unsigned d;
        logic        bit_val;
        logic        reached;
        ans        = '0;
        ans.status = ST_DONE;
        node       = 0;
        reached    = 1'b1;
        len        = (len_in > ADDRESS_BITS) ? ADDRESS_BITS : len_in;
        case (op)
            OP_INSERT: begin
                for (d = 0; d < len; d++) begin
                    bit_val = addr[ADDRESS_BITS - 1 - d];
                    if (!trie_kids[node][bit_val]) begin
                        // The walk stops at the first node that cannot be allocated.
                        if (trie_used >= NODE_COUNT) begin
                            ans.status = ST_FULL;
                            reached    = 1'b0;
                            break;
                        end
                        fresh = trie_used;
                        trie_used++;
                        trie_kids[fresh]   = '0;
                        trie_routed[fresh] = 1'b0;
                        trie_hop[fresh]    = '0;
                        if (bit_val) begin
                            trie_one_idx[node] = IDX_W'(fresh);
                        end else begin
                            trie_zero_idx[node] = IDX_W'(fresh);
                        end
                        trie_kids[node][bit_val] = 1'b1;
                    end
                    node = bit_val ? trie_one_idx[node] : trie_zero_idx[node];
                end
                if (reached) begin
                    trie_routed[node] = 1'b1;
                    trie_hop[node]    = hop;
                end
            end
            OP_LOOKUP: begin
                // The deepest routed node on the path wins.
                for (d = 0; d <= ADDRESS_BITS; d++) begin
                    if (trie_routed[node]) begin
                        ans.found = 1'b1;
                        ans.hop   = trie_hop[node];
                        ans.mlen  = LEN_W'(d);
                    end
                    if (d == ADDRESS_BITS) break;
                    bit_val = addr[ADDRESS_BITS - 1 - d];
                    if (!trie_kids[node][bit_val]) break;
                    node = bit_val ? trie_one_idx[node] : trie_zero_idx[node];
                end
            end
            OP_DELETE: begin
                for (d = 0; d < len; d++) begin
                    bit_val = addr[ADDRESS_BITS - 1 - d];
                    if (!trie_kids[node][bit_val]) begin
                        reached = 1'b0;
                        break;
                    end
                    node = bit_val ? trie_one_idx[node] : trie_zero_idx[node];
                end
                if (reached && trie_routed[node]) begin
                    trie_routed[node] = 1'b0;
                end else begin
                    ans.status = ST_ABSENT;
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // Offers one operation and records its answer once the transfer happens.
    task automatic send_route_op(input logic [1:0] op, input logic [31:0] addr,
                                 input logic [5:0] len, input logic [31:0] hop);
        int unsigned gap;
        gap = 0;
        if (idling_on && $urandom_range(99, 0) < IDLE_PERCENT) begin
            gap = $urandom_range(40, 1);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_prefix_len <= len;
        i_next_hop   <= hop;
        do @(posedge i_clk); while (!o_ready);
        expected_answers.push_back(trie_apply(op, addr, len, hop));
    endtask

    // Random operation, mostly close to one of the known prefixes.
    task automatic send_random_route_op();
        int unsigned pick;
        int unsigned spread;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [63:0] noise;
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
            op = OP_INSERT;
        end else if (pick < 75) begin
            op = OP_LOOKUP;
        end else if (pick < 95) begin
            op = OP_DELETE;
        end else begin
            op = OP_NOP;
        end
        // Flipping mostly at most the eight low bits keeps the paths shared and deep.
        spread = ($urandom_range(99, 0) < 85) ? $urandom_range(8, 0) : $urandom_range(32, 0);
        noise  = {32'd0, 32'($urandom)} & ((64'd1 << spread) - 64'd1);
        addr   = route_bases[$urandom_range(BASE_COUNT - 1, 0)] ^ noise[31:0];
        if ($urandom_range(99, 0) < 8) addr = $urandom;
        if ($urandom_range(99, 0) < 8) begin
            len = 6'($urandom_range(63, 33));
        end else begin
            len = 6'($urandom_range(32, 0));
        end
        send_route_op(op, addr, len, $urandom);
    endtask

    // Drops valid and waits until every pending answer has come back.
    task automatic settle_phase();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_route_op(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000);
        send_route_op(OP_DELETE, 32'h0000_0000, 6'd0,  32'h0000_0000);
        // Default route matches everything at length zero.
        send_route_op(OP_INSERT, 32'hDEAD_BEEF, 6'd0,  32'hC0A8_0001);
        send_route_op(OP_LOOKUP, 32'h8123_4567, 6'd0,  32'h0000_0000);
        send_route_op(OP_INSERT, 32'h0A00_0000, 6'd8,  32'hC0A8_0008);
        send_route_op(OP_INSERT, 32'h0A01_0000, 6'd16, 32'hC0A8_0010);
        send_route_op(OP_LOOKUP, 32'h0A01_0203, 6'd0,  32'h0000_0000);
        send_route_op(OP_LOOKUP, 32'h0A02_0000, 6'd32, 32'h0000_0000);
        send_route_op(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000);
        send_route_op(OP_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000);
        send_route_op(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000);
        // Lengths above the address width saturate, and a second insert overwrites.
        send_route_op(OP_INSERT, 32'h1234_5678, 6'd63, 32'h0101_0101);
        send_route_op(OP_LOOKUP, 32'h1234_5678, 6'd0,  32'h0000_0000);
        send_route_op(OP_INSERT, 32'h1234_5678, 6'd33, 32'h0202_0202);
        send_route_op(OP_LOOKUP, 32'h1234_5678, 6'd63, 32'h0000_0000);
        // Delete at an inner node that holds no route.
        send_route_op(OP_DELETE, 32'h0A00_0000, 6'd12, 32'h0000_0000);
        // Delete of a routed node with children leaves the subtree alone.
        send_route_op(OP_DELETE, 32'h0A00_0000, 6'd8,  32'h0000_0000);
        send_route_op(OP_LOOKUP, 32'h0A02_0304, 6'd0,  32'h0000_0000);
        send_route_op(OP_LOOKUP, 32'h0A01_0909, 6'd0,  32'h0000_0000);
        send_route_op(OP_DELETE, 32'h0B00_0000, 6'd8,  32'h0000_0000);
        send_route_op(OP_NOP,    32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        send_route_op(OP_DELETE, 32'h5555_AAAA, 6'd0,  32'h0000_0000);
        send_route_op(OP_LOOKUP, 32'h0A02_0304, 6'd0,  32'h0000_0000);
        send_route_op(OP_DELETE, 32'h0A00_0000, 6'd8,  32'h0000_0000);
        settle_phase();
    endtask

    task automatic test_random_routes();
        int unsigned k;
        for (k = 0; k < BASE_COUNT; k++) route_bases[k] = $urandom;
        for (k = 0; k < 1100; k++) begin
            // A stretch in the middle runs with both sides always ready.
            idling_on <= !(k >= 450 && k < 650);
            send_random_route_op();
        end
        idling_on <= 1'b1;
        settle_phase();
    endtask

    task automatic test_output_backpressure();
        int unsigned k;
        hold_asks <= hold_asks + 1;
        for (k = 0; k < 16; k++) send_random_route_op();
        settle_phase();
    endtask

    task automatic test_pool_exhaustion();
        int unsigned k;
        // Full-length random prefixes use up the node pool quickly.
        for (k = 0; k < 60; k++) send_route_op(OP_INSERT, $urandom, 6'd32, $urandom);
        for (k = 0; k < 300; k++) send_random_route_op();
        settle_phase();
    endtask

    // Result checker; also drives the receiver's ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_answers.size() == 0) begin
                    $error("result transfer with no operation pending");
                    mismatch_count++;
                end else begin
                    head_answer = expected_answers.pop_front();
                    if (o_found !== head_answer.found) begin
                        $error("found: expected %0d, got %0d", head_answer.found, o_found);
                        mismatch_count++;
                    end
                    if (o_result_hop !== head_answer.hop) begin
                        $error("result_hop: expected %h, got %h", head_answer.hop, o_result_hop);
                        mismatch_count++;
                    end
                    if (o_matched_len !== head_answer.mlen) begin
                        $error("matched_len: expected %0d, got %0d",
                               head_answer.mlen, o_matched_len);
                        mismatch_count++;
                    end
                    if (o_status !== head_answer.status) begin
                        $error("status: expected %0d, got %0d", head_answer.status, o_status);
                        mismatch_count++;
                    end
                end
            end
            // A new hold request starts a long stall of the output side.
            if (hold_asks != hold_taken) begin
                hold_taken <= hold_asks;
                hold_left  <= HOLD_OFF_CYCLES;
                i_ready    <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (idling_on) begin
                i_ready <= ($urandom_range(99, 0) >= IDLE_PERCENT);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        trie_kids[0]   = '0;
        trie_routed[0] = 1'b0;
        trie_used      = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_routes();
        test_output_backpressure();
        test_pool_exhaustion();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
